// File: rtl/wmp_pkg.sv
// Shared types, register indexes and helpers for the waste mode policy block.
package wmp_pkg;

   // Widths fixed by the interface
   localparam int LEVEL_W  = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int MODE_W   = 2;

   // Default width of the dwell and cooldown counters
   localparam int COUNT_BITS_DEFAULT = 16;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DWELL      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_ENTER     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_EXIT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_ENTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_EXIT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_COOLDOWN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_HOLD  = 3'd6;

   // Encoded mode on the result channel
   localparam logic [MODE_W-1:0] MODE_CODE_AGGRESSIVE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_SAFE       = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_RECOVERY   = 2'd2;

   // Policy mode, one-hot
   typedef enum logic [2:0] {
      MODE_AGGRESSIVE = 3'b001,
      MODE_SAFE       = 3'b010,
      MODE_RECOVERY   = 3'b100
   } mode_type;

   // Threshold and load registers
   typedef struct packed {
      logic [CSR_W-1:0] min_dwell;
      logic [CSR_W-1:0] safe_enter;
      logic [CSR_W-1:0] safe_exit;
      logic [CSR_W-1:0] recovery_enter;
      logic [CSR_W-1:0] recovery_exit;
      logic [CSR_W-1:0] safe_cooldown_load;
      logic [CSR_W-1:0] recovery_hold_load;
   } cfg_type;

   // Override flags of one transaction
   typedef struct packed {
      logic force_safe;
      logic force_recovery;
   } force_type;

   // Map the one-hot mode to its result code
   function automatic logic [MODE_W-1:0] mode_code(input mode_type mode);
      logic [MODE_W-1:0] code;
      unique case (mode)
         MODE_AGGRESSIVE: code = MODE_CODE_AGGRESSIVE;
         MODE_SAFE:       code = MODE_CODE_SAFE;
         default:         code = MODE_CODE_RECOVERY;
      endcase
      return code;
   endfunction

endpackage

// File: rtl/wmp_decide.sv
// Next-state logic of the policy machine: cooldowns, hysteresis, dwell and overrides.
module wmp_decide #(
   parameter int COUNT_BITS = wmp_pkg::COUNT_BITS_DEFAULT
) (
   input  wmp_pkg::cfg_type                  cfg,
   input  logic [wmp_pkg::LEVEL_W-1:0]       waste_level,
   input  logic [wmp_pkg::LEVEL_W-1:0]       pending_waste_level,
   input  wmp_pkg::force_type                force_flags,
   input  wmp_pkg::mode_type                 mode,
   input  logic [COUNT_BITS-1:0]             dwell_count,
   input  logic [COUNT_BITS-1:0]             safe_cooldown,
   input  logic [COUNT_BITS-1:0]             recovery_cooldown,
   output wmp_pkg::mode_type                 mode_next,
   output logic [COUNT_BITS-1:0]             dwell_count_next,
   output logic [COUNT_BITS-1:0]             safe_cooldown_next,
   output logic [COUNT_BITS-1:0]             recovery_cooldown_next
);
   import wmp_pkg::*;

   // Common width for comparing counters against 16-bit registers
   localparam int CMP_W = (COUNT_BITS > CSR_W) ? COUNT_BITS : CSR_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [CMP_W-1:0] COUNT_MAX_W = CMP_W'(COUNT_MAX);

   logic [LEVEL_W-1:0]    metric;
   logic [COUNT_BITS-1:0] safe_cd_dec;
   logic [COUNT_BITS-1:0] rec_cd_dec;
   logic [CMP_W-1:0]      safe_load_w;
   logic [CMP_W-1:0]      rec_load_w;
   logic [COUNT_BITS-1:0] safe_load;
   logic [COUNT_BITS-1:0] rec_load;
   logic                  may_move;
   mode_type              mode_want;

   // Take the larger of the two levels as the metric
   assign metric = (waste_level >= pending_waste_level) ? waste_level : pending_waste_level;

   // Count both cooldowns down, stopping at zero
   assign safe_cd_dec = (safe_cooldown == '0) ? '0 : safe_cooldown - COUNT_BITS'(1);
   assign rec_cd_dec  = (recovery_cooldown == '0) ? '0 : recovery_cooldown - COUNT_BITS'(1);

   // Clamp the cooldown loads to the counter width
   assign safe_load_w = CMP_W'(cfg.safe_cooldown_load);
   assign rec_load_w  = CMP_W'(cfg.recovery_hold_load);
   assign safe_load   = (safe_load_w > COUNT_MAX_W) ? COUNT_MAX : safe_load_w[COUNT_BITS-1:0];
   assign rec_load    = (rec_load_w > COUNT_MAX_W) ? COUNT_MAX : rec_load_w[COUNT_BITS-1:0];

   // Overrides bypass the minimum dwell
   assign may_move = force_flags.force_safe | force_flags.force_recovery |
                     (CMP_W'(dwell_count) >= CMP_W'(cfg.min_dwell));

   // Pick the wanted mode: recovery override first, then safe override, then hysteresis
   always_comb begin
      mode_want = mode;
      priority if (force_flags.force_recovery) begin
         mode_want = MODE_RECOVERY;
      end else if (force_flags.force_safe) begin
         mode_want = MODE_SAFE;
      end else begin
         unique case (mode)
            MODE_AGGRESSIVE: begin
               if (metric >= cfg.safe_enter) mode_want = MODE_SAFE;
            end
            MODE_SAFE: begin
               priority if (metric >= cfg.recovery_enter) begin
                  mode_want = MODE_RECOVERY;
               end else if (metric <= cfg.safe_exit && safe_cd_dec == '0) begin
                  mode_want = MODE_AGGRESSIVE;
               end else begin
                  mode_want = mode;
               end
            end
            default: begin
               if (metric <= cfg.recovery_exit && rec_cd_dec == '0) mode_want = MODE_SAFE;
            end
         endcase
      end
   end

   // Apply the dwell gate, restart the dwell on a change and load the new cooldown
   always_comb begin
      mode_next              = may_move ? mode_want : mode;
      safe_cooldown_next     = safe_cd_dec;
      recovery_cooldown_next = rec_cd_dec;
      if (mode_next != mode) begin
         dwell_count_next = COUNT_BITS'(1);
         if (mode_next == MODE_SAFE) safe_cooldown_next = safe_load;
         if (mode_next == MODE_RECOVERY) recovery_cooldown_next = rec_load;
      end else if (dwell_count != COUNT_MAX) begin
         dwell_count_next = dwell_count + COUNT_BITS'(1);
      end else begin
         dwell_count_next = dwell_count;
      end
   end

endmodule

// File: rtl/waste_mode_policy_fsm_top.sv
// Top level of the waste mode policy machine: channels, state and result register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | waste levels, force flags
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_mode_out
//   csr     | in        | csr_write_en         | csr_index, csr_wdata
//
// One transaction per cycle while rsp_ready is high; results appear the cycle after acceptance.
// The decision is one level of compares and counter updates into the state and result registers.
// req_ready is high when the result register is empty or its result leaves in the same cycle.
// Reset returns the mode to aggressive and clears the counters, settings and rsp_valid.
module waste_mode_policy_fsm_top #(
   parameter int COUNT_BITS = wmp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [wmp_pkg::LEVEL_W-1:0]        req_waste_level,
   input  logic [wmp_pkg::LEVEL_W-1:0]        req_pending_waste_level,
   input  logic                               req_force_safe,
   input  logic                               req_force_recovery,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [wmp_pkg::MODE_W-1:0]         rsp_mode_out,
   input  logic                               csr_write_en,
   input  logic [wmp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wmp_pkg::CSR_W-1:0]          csr_wdata
);
   import wmp_pkg::*;

   cfg_type               cfg_ff;
   mode_type              mode_ff;
   mode_type              mode_in;
   logic [COUNT_BITS-1:0] dwell_ff;
   logic [COUNT_BITS-1:0] dwell_in;
   logic [COUNT_BITS-1:0] safe_cd_ff;
   logic [COUNT_BITS-1:0] safe_cd_in;
   logic [COUNT_BITS-1:0] rec_cd_ff;
   logic [COUNT_BITS-1:0] rec_cd_in;
   logic                  rsp_valid_ff;
   logic [MODE_W-1:0]     rsp_mode_ff;
   logic                  req_fire;
   force_type             force_flags;

   assign req_ready   = ~rsp_valid_ff | rsp_ready;
   assign req_fire    = req_valid & req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_mode_out = rsp_mode_ff;
   assign force_flags = '{force_safe: req_force_safe, force_recovery: req_force_recovery};

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MIN_DWELL:      cfg_ff.min_dwell          <= csr_wdata;
            CSR_SAFE_ENTER:     cfg_ff.safe_enter         <= csr_wdata;
            CSR_SAFE_EXIT:      cfg_ff.safe_exit          <= csr_wdata;
            CSR_RECOVERY_ENTER: cfg_ff.recovery_enter     <= csr_wdata;
            CSR_RECOVERY_EXIT:  cfg_ff.recovery_exit      <= csr_wdata;
            CSR_SAFE_COOLDOWN:  cfg_ff.safe_cooldown_load <= csr_wdata;
            CSR_RECOVERY_HOLD:  cfg_ff.recovery_hold_load <= csr_wdata;
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   wmp_decide #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decide (
      .cfg                    (cfg_ff),
      .waste_level            (req_waste_level),
      .pending_waste_level    (req_pending_waste_level),
      .force_flags            (force_flags),
      .mode                   (mode_ff),
      .dwell_count            (dwell_ff),
      .safe_cooldown          (safe_cd_ff),
      .recovery_cooldown      (rec_cd_ff),
      .mode_next              (mode_in),
      .dwell_count_next       (dwell_in),
      .safe_cooldown_next     (safe_cd_in),
      .recovery_cooldown_next (rec_cd_in)
   );

   // Advance the policy state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_AGGRESSIVE;
         dwell_ff   <= '0;
         safe_cd_ff <= '0;
         rec_cd_ff  <= '0;
      end else if (req_fire) begin
         mode_ff    <= mode_in;
         dwell_ff   <= dwell_in;
         safe_cd_ff <= safe_cd_in;
         rec_cd_ff  <= rec_cd_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_mode_ff <= mode_code(mode_in);
      end
   end

`ifndef SYNTH
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while result register is stalled");

   a_force_recovery_wins: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_force_recovery |=> rsp_mode_out == MODE_CODE_RECOVERY)
      else $error("recovery override did not select recovery");

   a_change_restarts_dwell: assert property (@(posedge clock) disable iff (reset)
      req_fire && mode_in != mode_ff |=> dwell_ff == COUNT_BITS'(1))
      else $error("mode change did not restart the dwell count");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(mode_ff) && $stable(dwell_ff) && $stable(safe_cd_ff))
      else $error("policy state moved without a transaction");
`endif

endmodule

// File: bench/waste_mode_policy_fsm_top_test.sv
// Self-checking testbench for the waste mode policy machine: directed, random and dwell soak.

// Track the policy state, predict each returned mode and compare.
class mode_scoreboard;
   localparam int COUNT_W = wmp_pkg::COUNT_BITS_DEFAULT;
   localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_W) - 33'd1;

   wmp_pkg::cfg_type settings = '0;
   logic [wmp_pkg::MODE_W-1:0] mode = wmp_pkg::MODE_CODE_AGGRESSIVE;
   logic [COUNT_W-1:0] dwell = '0;
   logic [COUNT_W-1:0] safe_hold = '0;
   logic [COUNT_W-1:0] recovery_hold = '0;
   logic [wmp_pkg::MODE_W-1:0] expected_modes[$];
   int unsigned mismatches = 0;
   int unsigned modes_checked = 0;

   // Mirror one register write
   function void set_register(input logic [wmp_pkg::CSR_IDX_W-1:0] idx,
                              input logic [wmp_pkg::CSR_W-1:0] value);
      case (idx)
         wmp_pkg::CSR_MIN_DWELL:      settings.min_dwell = value;
         wmp_pkg::CSR_SAFE_ENTER:     settings.safe_enter = value;
         wmp_pkg::CSR_SAFE_EXIT:      settings.safe_exit = value;
         wmp_pkg::CSR_RECOVERY_ENTER: settings.recovery_enter = value;
         wmp_pkg::CSR_RECOVERY_EXIT:  settings.recovery_exit = value;
         wmp_pkg::CSR_SAFE_COOLDOWN:  settings.safe_cooldown_load = value;
         wmp_pkg::CSR_RECOVERY_HOLD:  settings.recovery_hold_load = value;
         default: ;
      endcase
   endfunction

   // Saturate a 16-bit load into the counter width
   function logic [COUNT_W-1:0] clamp_load(input logic [wmp_pkg::CSR_W-1:0] load);
      return (33'(load) > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : COUNT_W'(load);
   endfunction

   // Advance the policy by one accepted decision and queue the mode it ends in
   function void note_decision(input logic [wmp_pkg::LEVEL_W-1:0] waste,
                               input logic [wmp_pkg::LEVEL_W-1:0] pending_level,
                               input logic force_safe,
                               input logic force_recovery);
      logic [wmp_pkg::LEVEL_W-1:0] metric;
      logic [wmp_pkg::MODE_W-1:0] mode_after;
      logic may_move;
      metric = (waste >= pending_level) ? waste : pending_level;
      if (safe_hold != '0) safe_hold = safe_hold - 1'b1;
      if (recovery_hold != '0) recovery_hold = recovery_hold - 1'b1;
      may_move = force_safe || force_recovery || (32'(dwell) >= 32'(settings.min_dwell));

      // Overrides first, then the hysteresis of the current mode
      mode_after = mode;
      if (force_recovery) begin
         mode_after = wmp_pkg::MODE_CODE_RECOVERY;
      end else if (force_safe) begin
         mode_after = wmp_pkg::MODE_CODE_SAFE;
      end else begin
         case (mode)
            wmp_pkg::MODE_CODE_AGGRESSIVE: begin
               if (metric >= settings.safe_enter) mode_after = wmp_pkg::MODE_CODE_SAFE;
            end
            wmp_pkg::MODE_CODE_SAFE: begin
               if (metric >= settings.recovery_enter)
                  mode_after = wmp_pkg::MODE_CODE_RECOVERY;
               else if (metric <= settings.safe_exit && safe_hold == '0)
                  mode_after = wmp_pkg::MODE_CODE_AGGRESSIVE;
            end
            default: begin
               if (metric <= settings.recovery_exit && recovery_hold == '0)
                  mode_after = wmp_pkg::MODE_CODE_SAFE;
            end
         endcase
      end
      if (!may_move) mode_after = mode;

      // Restart dwell and load the cooldown on a change, else count dwell up
      if (mode_after != mode) begin
         mode = mode_after;
         dwell = COUNT_W'(1);
         if (mode_after == wmp_pkg::MODE_CODE_SAFE)
            safe_hold = clamp_load(settings.safe_cooldown_load);
         else if (mode_after == wmp_pkg::MODE_CODE_RECOVERY)
            recovery_hold = clamp_load(settings.recovery_hold_load);
      end else if (dwell != '1) begin
         dwell = dwell + 1'b1;
      end
      expected_modes.push_back(mode);
   endfunction

   function bit all_returned();
      return expected_modes.size() == 0;
   endfunction

   task report_mismatch(input string what);
      if (mismatches < 40) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Compare one returned mode with the oldest prediction
   task check_mode(input logic [wmp_pkg::MODE_W-1:0] got);
      logic [wmp_pkg::MODE_W-1:0] want;
      if (expected_modes.size() == 0) begin
         report_mismatch($sformatf("mode %0d returned with no decision outstanding", got));
         return;
      end
      want = expected_modes.pop_front();
      if (got !== want)
         report_mismatch($sformatf("decision %0d: mode_out %0d, predicted %0d",
                                   modes_checked, got, want));
      modes_checked++;
   endtask
endclass

module waste_mode_policy_fsm_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wmp_pkg::*;

   localparam int COUNT_W = COUNT_BITS_DEFAULT;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 203;
   localparam int SOAK_ITEMS = 200;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [LEVEL_W-1:0]   req_waste_level = '0;
   logic [LEVEL_W-1:0]   req_pending_waste_level = '0;
   logic                 req_force_safe = 1'b0;
   logic                 req_force_recovery = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [MODE_W-1:0]    rsp_mode_out;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Set to turn off idling on both sides
   bit steady = 1'b0;
   mode_scoreboard board = new;

   waste_mode_policy_fsm_top #(.COUNT_BITS(COUNT_W)) u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Check each returned mode, then pick the next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_mode(rsp_mode_out);
      rsp_ready <= steady || ($urandom_range(99) >= 29);
   end

   // Offer one decision, hold it until taken, then predict it
   task automatic send_decision(input logic [LEVEL_W-1:0] waste,
                                input logic [LEVEL_W-1:0] pending_level,
                                input logic force_safe,
                                input logic force_recovery);
      if (!steady) begin
         while ($urandom_range(99) < 29) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_waste_level <= waste;
      req_pending_waste_level <= pending_level;
      req_force_safe <= force_safe;
      req_force_recovery <= force_recovery;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_decision(waste, pending_level, force_safe, force_recovery);
   endtask

   // Drop valid and hold until every predicted mode has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (!board.all_returned()) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.set_register(idx, value);
   endtask

   task automatic load_settings(input cfg_type cfg);
      write_register(CSR_MIN_DWELL, cfg.min_dwell);
      write_register(CSR_SAFE_ENTER, cfg.safe_enter);
      write_register(CSR_SAFE_EXIT, cfg.safe_exit);
      write_register(CSR_RECOVERY_ENTER, cfg.recovery_enter);
      write_register(CSR_RECOVERY_EXIT, cfg.recovery_exit);
      write_register(CSR_SAFE_COOLDOWN, cfg.safe_cooldown_load);
      write_register(CSR_RECOVERY_HOLD, cfg.recovery_hold_load);
      csr_write_en <= 1'b0;
   endtask

   // Mostly ordered hysteresis bands with short dwell and cooldowns
   function automatic cfg_type random_settings();
      cfg_type cfg;
      cfg.min_dwell = CSR_W'($urandom_range(6));
      cfg.safe_cooldown_load = CSR_W'($urandom_range(8));
      cfg.recovery_hold_load = CSR_W'($urandom_range(8));
      if ($urandom_range(3) == 0) begin
         cfg.safe_enter = CSR_W'($urandom);
         cfg.safe_exit = CSR_W'($urandom);
         cfg.recovery_enter = CSR_W'($urandom);
         cfg.recovery_exit = CSR_W'($urandom);
      end else begin
         cfg.safe_exit = CSR_W'($urandom_range(600));
         cfg.safe_enter = cfg.safe_exit + CSR_W'($urandom_range(1, 300));
         cfg.recovery_exit = cfg.safe_enter + CSR_W'($urandom_range(200));
         cfg.recovery_enter = cfg.recovery_exit + CSR_W'($urandom_range(1, 300));
      end
      return cfg;
   endfunction

   // Pick a level: extremes, full range, a low range up to 1100, or just around one of the thresholds
   function automatic logic [LEVEL_W-1:0] pick_level(input cfg_type cfg);
      int level;
      int jitter;
      jitter = int'($urandom_range(4)) - 2;
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return LEVEL_W'($urandom);
         4: level = cfg.safe_enter;
         5: level = cfg.safe_exit;
         6: level = cfg.recovery_enter;
         7: level = cfg.recovery_exit;
         default: return LEVEL_W'($urandom_range(1100));
      endcase
      level = level + jitter;
      if (level < 0) level = 0;
      else if (level > 65535) level = 65535;
      return LEVEL_W'(level);
   endfunction

   // Random decisions around the thresholds, with some plain noise
   task automatic run_random_phase(input cfg_type cfg, input int count, input bit pause_midway);
      for (int n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2) wait_for_results();
         if ($urandom_range(9) == 0)
            send_decision(LEVEL_W'($urandom), LEVEL_W'($urandom), 1'($urandom), 1'($urandom));
         else
            send_decision(pick_level(cfg), pick_level(cfg),
                          $urandom_range(99) < 6, $urandom_range(99) < 4);
      end
   endtask

   // Sit in safe mode under a long minimum dwell, then climb once it has passed
   task automatic soak_dwell();
      cfg_type cfg;
      cfg = '{min_dwell: CSR_W'(SOAK_ITEMS), safe_enter: '1, safe_exit: '0,
              recovery_enter: '1, recovery_exit: '0, safe_cooldown_load: '0,
              recovery_hold_load: '0};
      load_settings(cfg);
      send_decision(16'h0001, 16'h0001, 1'b0, 1'b1);
      send_decision(16'h0001, 16'h0001, 1'b1, 1'b0);
      for (int n = 0; n < SOAK_ITEMS; n++) begin
         if (n < SOAK_ITEMS - 20 && $urandom_range(15) == 0)
            send_decision(16'hFFFF, LEVEL_W'($urandom), 1'b0, 1'b0);
         else
            send_decision(LEVEL_W'($urandom_range(16'hFFFE, 1)),
                          LEVEL_W'($urandom_range(16'hFFFE, 1)), 1'b0, 1'b0);
      end
      // dwell has reached the minimum here, so the climb goes through
      send_decision(16'hFFFF, 16'h0000, 1'b0, 1'b0);
   endtask

   initial begin
      cfg_type cfg;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: dwell, cooldowns and overrides with narrow bands
      cfg = '{min_dwell: 16'd2, safe_enter: 16'd400, safe_exit: 16'd200,
              recovery_enter: 16'd800, recovery_exit: 16'd500,
              safe_cooldown_load: 16'd3, recovery_hold_load: 16'd4};
      load_settings(cfg);
      send_decision(16'h0000, 16'h0000, 1'b0, 1'b0);
      send_decision(16'hFFFF, 16'h0000, 1'b0, 1'b0);  // blocked by min dwell
      send_decision(16'h0000, 16'hFFFF, 1'b0, 1'b0);  // pending level drives the climb
      send_decision(16'd100, 16'd50, 1'b0, 1'b0);     // held by cooldown
      send_decision(16'd100, 16'd0, 1'b0, 1'b0);
      send_decision(16'd0, 16'd150, 1'b0, 1'b0);      // cooldown expired, back to aggressive
      send_decision(16'h0000, 16'h0000, 1'b1, 1'b0);  // force safe bypasses dwell
      send_decision(16'h0000, 16'h0000, 1'b1, 1'b0);  // force to current mode, no reload
      send_decision(16'h0000, 16'h0000, 1'b1, 1'b1);  // recovery override wins
      send_decision(16'h0000, 16'h0000, 1'b0, 1'b1);
      send_decision(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
      send_decision(16'd500, 16'd500, 1'b0, 1'b0);    // hold count still running
      send_decision(16'd500, 16'd0, 1'b0, 1'b0);
      send_decision(16'hFFFF, 16'h0000, 1'b0, 1'b0);
      send_decision(16'd900, 16'd0, 1'b0, 1'b0);
      send_decision(16'h0000, 16'h0000, 1'b1, 1'b0);
      send_decision(16'h0000, 16'h0000, 1'b0, 1'b1);
      wait_for_results();

      // Directed: overlapping bands, so safe sees the recovery entry and the safe exit at once
      cfg = '{min_dwell: 16'd0, safe_enter: 16'd0, safe_exit: 16'hFFFF,
              recovery_enter: 16'h8000, recovery_exit: 16'd0,
              safe_cooldown_load: 16'd0, recovery_hold_load: 16'd0};
      load_settings(cfg);
      send_decision(16'h0000, 16'h0000, 1'b1, 1'b0);
      send_decision(16'h9000, 16'h0100, 1'b0, 1'b0);  // climb to recovery wins
      send_decision(16'h0000, 16'h0000, 1'b0, 1'b0);
      send_decision(16'h0010, 16'h0020, 1'b0, 1'b0);  // enter aggressive, nothing loaded
      send_decision(16'h0000, 16'h0000, 1'b0, 1'b0);

      // Random phases: all-zero and all-one settings first, then random bands
      for (int p = 0; p < PHASES; p++) begin
         wait_for_results();
         if (p == 0) cfg = '0;
         else if (p == 1) cfg = '1;
         else cfg = random_settings();
         load_settings(cfg);
         steady = (p == 4);
         run_random_phase(cfg, ITEMS_PER_PHASE, p == 2);
      end
      steady = 1'b0;
      wait_for_results();

      soak_dwell();
      wait_for_results();

      if (board.mismatches == 0)
         $display("waste_mode_policy_fsm_top verification clean");
      else
         $display("waste_mode_policy_fsm_top verification failed");
      $finish;
   end

   // Abort a hung run
   initial begin
      #8ms;
      $display("waste_mode_policy_fsm_top verification failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/wmp_pkg.sv
rtl/wmp_decide.sv
rtl/waste_mode_policy_fsm_top.sv
bench/waste_mode_policy_fsm_top_test.sv
